/* design/kws_pkg.sv */
// Shared constants and types for the kinematic window selection block.
package kws_pkg;

  localparam int KWS_BOUND_WIDTH = 16;
  localparam int NUM_REGS = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_W = 64;

  localparam logic [CFG_ADDR_W-1:0] REG_PT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MOM = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_THETA = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RAP = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PHI = 3'd4;

  localparam logic [REG_W-1:0] PT_RESET = 64'hFFFF0000FFFF0000;
  localparam logic [REG_W-1:0] MOM_RESET = 64'hFFFF0000FFFF0000;
  localparam logic [REG_W-1:0] THETA_RESET = 64'h6488000064880000;
  localparam logic [REG_W-1:0] RAP_RESET = 64'h6000A0006000A000;
  localparam logic [REG_W-1:0] PHI_RESET = 64'hC9100000C9100000;

  localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

  localparam int SQ_W = 34;
  localparam int ROOT_W = 17;
  localparam int N_W = 36;
  localparam int K_W = 6;
  localparam int FRAC_W = 16;
  localparam int LOG_W = K_W + FRAC_W;
  localparam int MANT_W = 31;
  localparam int PROD_W = LOG_W + 32;

  localparam logic signed [15:0] Y_MAX = 16'sh7FFF;
  localparam logic signed [15:0] Y_MIN = 16'sh8000;

  typedef struct packed {
    logic [15:0] pt;
    logic [15:0] p;
    logic [14:0] theta;
    logic [15:0] phi;
    logic        cls;
    logic        pz_neg;
    logic [15:0] pz_abs;
    logic [15:0] energy;
    logic [32:0] tsq;
  } side_t;

  typedef struct packed {
    logic [15:0] pt;
    logic [15:0] p;
    logic [14:0] theta;
    logic [15:0] phi;
    logic        cls;
    logic        pz_neg;
    logic        t_zero;
    logic        n_zero;
  } side2_t;

endpackage

/* design/kws_if.sv */
// Channel interfaces for particle items, result items and register writes.
interface kws_in_if ();
  logic               valid;
  logic               ready;
  logic signed [15:0] long_momentum;
  logic [15:0]        transverse_momentum;
  logic [15:0]        total_momentum;
  logic [14:0]        polar_angle;
  logic [15:0]        azimuth;
  logic [15:0]        energy;
  logic [15:0]        rest_mass;
  logic               particle_class;

  modport source (output valid, long_momentum, transverse_momentum, total_momentum,
                  polar_angle, azimuth, energy, rest_mass, particle_class, input ready);
  modport sink (input valid, long_momentum, transverse_momentum, total_momentum,
                polar_angle, azimuth, energy, rest_mass, particle_class, output ready);
endinterface

interface kws_out_if ();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic signed [15:0] rapidity;

  modport source (output valid, accepted, rapidity, input ready);
  modport sink (input valid, accepted, rapidity, output ready);
endinterface

interface kws_cfg_if ();
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [63:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

/* design/kws_sqrt.sv */
// Pipelined integer square root, up to two result bits per stage.
module kws_sqrt #(
  parameter int TAG_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [kws_pkg::SQ_W-1:0]    x,
  input  logic [TAG_W-1:0]            tag_in,
  output logic                        out_valid,
  output logic [kws_pkg::ROOT_W-1:0]  root,
  output logic [TAG_W-1:0]            tag_out
);

  localparam int STEPS = kws_pkg::ROOT_W;
  localparam int STAGES = (STEPS + 1) / 2;
  localparam int W = kws_pkg::SQ_W;

  logic [STAGES-1:0] vld;
  logic [W-1:0]      rem_r [STAGES];
  logic [W-1:0]      res_r [STAGES];
  logic [TAG_W-1:0]  tag_r [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [W-1:0]     rem_i;
    logic [W-1:0]     res_i;
    logic [W-1:0]     rem_o;
    logic [W-1:0]     res_o;
    logic             vld_i;
    logic [TAG_W-1:0] tag_i;

    if (g == 0) begin : g_first
      assign rem_i = x;
      assign res_i = '0;
      assign vld_i = in_valid;
      assign tag_i = tag_in;
    end else begin : g_rest
      assign rem_i = rem_r[g-1];
      assign res_i = res_r[g-1];
      assign vld_i = vld[g-1];
      assign tag_i = tag_r[g-1];
    end

    always_comb begin
      logic [W-1:0] rm;
      logic [W-1:0] rs;
      logic [W-1:0] bt;
      rm = rem_i;
      rs = res_i;
      bt = '0;
      for (int j = 0; j < 2; j++) begin
        if (2 * g + j < STEPS) begin
          bt = W'(1) << (2 * (STEPS - 1 - (2 * g + j)));
          if (rm >= rs + bt) begin
            rm = rm - (rs + bt);
            rs = (rs >> 1) + bt;
          end else begin
            rs = rs >> 1;
          end
        end
      end
      rem_o = rm;
      res_o = rs;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_o;
        res_r[g] <= res_o;
        tag_r[g] <= tag_i;
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign root = res_r[STAGES-1][STEPS-1:0];
  assign tag_out = tag_r[STAGES-1];

endmodule

/* design/kws_log2.sv */
// Pipelined two-lane base-2 logarithm by repeated squaring, one fraction bit per squaring stage.
module kws_log2 #(
  parameter int TAG_W = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [1:0][kws_pkg::N_W-1:0]      x,
  input  logic [TAG_W-1:0]                  tag_in,
  output logic                              out_valid,
  output logic [1:0][kws_pkg::LOG_W-1:0]    lg,
  output logic [TAG_W-1:0]                  tag_out
);

  localparam int NW = kws_pkg::N_W;
  localparam int MW = kws_pkg::MANT_W;
  localparam int KW = kws_pkg::K_W;
  localparam int FW = kws_pkg::FRAC_W;

  logic                 vld0;
  logic [1:0][NW-1:0]   x0_r;
  logic [1:0][KW-1:0]   k0_r;
  logic [TAG_W-1:0]     tag0_r;
  logic [1:0][KW-1:0]   k_enc;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      k_enc[l] = '0;
      for (int b = 0; b < NW; b++) begin
        if (x[l][b]) begin
          k_enc[l] = KW'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else if (en) begin
      vld0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= x;
      k0_r <= k_enc;
      tag0_r <= tag_in;
    end
  end

  logic [FW:0]        vld;
  logic [1:0][MW-1:0] m_r [FW+1];
  logic [1:0][FW-1:0] f_r [FW+1];
  logic [1:0][KW-1:0] k_r [FW+1];
  logic [TAG_W-1:0]   tag_r [FW+1];
  logic [1:0][MW-1:0] m_norm;

  always_comb begin
    logic [NW+MW-1:0] wide;
    for (int l = 0; l < 2; l++) begin
      wide = {x0_r[l], MW'(0)} >> (k0_r[l] + KW'(1));
      m_norm[l] = wide[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= vld0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= m_norm;
      f_r[0] <= '0;
      k_r[0] <= k0_r;
      tag_r[0] <= tag0_r;
    end
  end

  for (genvar g = 0; g < FW; g++) begin : g_sq
    logic [1:0][MW-1:0] m_o;
    logic [1:0][FW-1:0] f_o;

    always_comb begin
      logic [2*MW-1:0] sq;
      logic [MW:0]     t;
      for (int l = 0; l < 2; l++) begin
        sq = (2*MW)'(m_r[g][l]) * (2*MW)'(m_r[g][l]);
        t = sq[2*MW-1:MW-1];
        if (t[MW]) begin
          m_o[l] = t[MW:1];
          f_o[l] = {f_r[g][l][FW-2:0], 1'b1};
        end else begin
          m_o[l] = t[MW-1:0];
          f_o[l] = {f_r[g][l][FW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[g+1] <= m_o;
        f_r[g+1] <= f_o;
        k_r[g+1] <= k_r[g];
        tag_r[g+1] <= tag_r[g];
      end
    end
  end

  assign out_valid = vld[FW];
  assign tag_out = tag_r[FW];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      lg[l] = {k_r[FW][l], f_r[FW][l]};
    end
  end

endmodule

/* design/kinematic_window_selection_top.sv */
// Top level of the kinematic window selection block: rapidity and window checks.
//
// Channel   Modport  Payload
// item_in   sink     pz, pt, p, theta, phi, energy, mass, class
// item_out  source   accepted, rapidity
// cfg       sink     addr (register index), data (64-bit window register)
//
// One item enters per cycle while item_out is not stalled.
// The pipeline includes the nine square-root stages and the eighteen log stages.
// Reset is synchronous; it empties the pipeline and restores the default windows.
// A stall on item_out freezes every stage, and item_in.ready falls with it.
module kinematic_window_selection_top #(
  parameter int BOUND_WIDTH = kws_pkg::KWS_BOUND_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  kws_in_if.sink    item_in,
  kws_out_if.source item_out,
  kws_cfg_if.sink   cfg
);

  localparam int BW = BOUND_WIDTH;
  localparam int CW = 33;
  localparam int SIDE_W = $bits(kws_pkg::side_t);
  localparam int SIDE2_W = $bits(kws_pkg::side2_t);
  localparam int NW = kws_pkg::N_W;
  localparam int LW = kws_pkg::LOG_W;
  localparam int PW = kws_pkg::PROD_W;

  logic en;
  assign en = !item_out.valid || item_out.ready;
  assign item_in.ready = en;

  // Window registers.
  logic [kws_pkg::REG_W-1:0] win [kws_pkg::NUM_REGS];
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      win[kws_pkg::REG_PT] <= kws_pkg::PT_RESET;
      win[kws_pkg::REG_MOM] <= kws_pkg::MOM_RESET;
      win[kws_pkg::REG_THETA] <= kws_pkg::THETA_RESET;
      win[kws_pkg::REG_RAP] <= kws_pkg::RAP_RESET;
      win[kws_pkg::REG_PHI] <= kws_pkg::PHI_RESET;
    end else if (cfg.valid && cfg.addr < kws_pkg::CFG_ADDR_W'(kws_pkg::NUM_REGS)) begin
      win[cfg.addr] <= cfg.data;
    end
  end

  logic [BW-1:0] fld [kws_pkg::NUM_REGS][4];
  always_comb begin
    logic [2*kws_pkg::REG_W-1:0] ext;
    for (int r = 0; r < kws_pkg::NUM_REGS; r++) begin
      for (int f = 0; f < 4; f++) begin
        ext = {kws_pkg::REG_W'(0), win[r]} >> (f * BW);
        fld[r][f] = ext[BW-1:0];
      end
    end
  end

  // Stage 1: squares and magnitude of pz.
  logic                  s1_valid;
  logic [kws_pkg::SQ_W-1:0] s1_psq;
  kws_pkg::side_t        s1_side;
  kws_pkg::side_t        s1_side_next;
  logic [kws_pkg::SQ_W-1:0] psq_next;

  always_comb begin
    psq_next = kws_pkg::SQ_W'(item_in.total_momentum) * kws_pkg::SQ_W'(item_in.total_momentum)
             + kws_pkg::SQ_W'(item_in.rest_mass) * kws_pkg::SQ_W'(item_in.rest_mass);
    s1_side_next.pt = item_in.transverse_momentum;
    s1_side_next.p = item_in.total_momentum;
    s1_side_next.theta = item_in.polar_angle;
    s1_side_next.phi = item_in.azimuth;
    s1_side_next.cls = item_in.particle_class;
    s1_side_next.pz_neg = item_in.long_momentum[15];
    s1_side_next.pz_abs = item_in.long_momentum[15] ? 16'(-item_in.long_momentum)
                                                    : 16'(item_in.long_momentum);
    s1_side_next.energy = item_in.energy;
    s1_side_next.tsq = 33'(item_in.transverse_momentum) * 33'(item_in.transverse_momentum)
                     + 33'(item_in.rest_mass) * 33'(item_in.rest_mass);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= item_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_psq <= psq_next;
      s1_side <= s1_side_next;
    end
  end

  // Derived energy.
  logic                       sq_valid;
  logic [kws_pkg::ROOT_W-1:0] sq_root;
  logic [SIDE_W-1:0]          sq_tag;
  kws_pkg::side_t             sq_side;

  kws_sqrt #(.TAG_W(SIDE_W)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s1_valid),
    .x         (s1_psq),
    .tag_in    (SIDE_W'(s1_side)),
    .out_valid (sq_valid),
    .root      (sq_root),
    .tag_out   (sq_tag)
  );

  assign sq_side = kws_pkg::side_t'(sq_tag);

  // Stage A: e + |pz|.
  logic           a_valid;
  logic [17:0]    a_sum;
  kws_pkg::side_t a_side;
  logic [16:0]    e_sel;

  assign e_sel = (sq_side.energy == 16'd0) ? sq_root : 17'(sq_side.energy);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sum <= 18'(e_sel) + 18'(sq_side.pz_abs);
      a_side <= sq_side;
    end
  end

  // Stage B: numerator square.
  logic            b_valid;
  logic [NW-1:0]   b_n2;
  logic [NW-1:0]   b_tsq;
  kws_pkg::side2_t b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_n2 <= NW'(a_sum) * NW'(a_sum);
      b_tsq <= NW'(a_side.tsq);
      b_side.pt <= a_side.pt;
      b_side.p <= a_side.p;
      b_side.theta <= a_side.theta;
      b_side.phi <= a_side.phi;
      b_side.cls <= a_side.cls;
      b_side.pz_neg <= a_side.pz_neg;
      b_side.t_zero <= (a_side.tsq == 33'd0);
      b_side.n_zero <= (a_sum == 18'd0);
    end
  end

  // Logarithms of numerator and denominator.
  logic                 lg_valid;
  logic [1:0][LW-1:0]   lg;
  logic [SIDE2_W-1:0]   lg_tag;
  kws_pkg::side2_t      lg_side;

  kws_log2 #(.TAG_W(SIDE2_W)) u_log2 (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_valid),
    .x         ({b_tsq, b_n2}),
    .tag_in    (SIDE2_W'(b_side)),
    .out_valid (lg_valid),
    .lg        (lg),
    .tag_out   (lg_tag)
  );

  assign lg_side = kws_pkg::side2_t'(lg_tag);

  // Stage D: difference of logarithms.
  logic            d_valid;
  logic [LW-1:0]   d_mag;
  logic            d_neg;
  kws_pkg::side2_t d_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= lg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_mag <= (lg[0] < lg[1]) ? lg[1] - lg[0] : lg[0] - lg[1];
      d_neg <= (lg[0] < lg[1]) != lg_side.pz_neg;
      d_side <= lg_side;
    end
  end

  // Stage R: scale by ln 2.
  logic            r_valid;
  logic [PW-1:0]   r_prod;
  logic            r_neg;
  kws_pkg::side2_t r_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (en) begin
      r_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_prod <= PW'(d_mag) * PW'(kws_pkg::LN2_Q32);
      r_neg <= d_neg;
      r_side <= d_side;
    end
  end

  // Stage Y: round and saturate.
  logic               y_valid;
  logic signed [15:0] y_r;
  kws_pkg::side2_t    y_side;
  logic signed [15:0] y_next;
  logic [16:0]        mag;

  always_comb begin
    logic [PW:0] rounded;
    rounded = (PW + 1)'(r_prod) + ((PW + 1)'(1) << 37);
    mag = 17'(rounded >> 38);
    if (r_side.t_zero) begin
      y_next = r_side.pz_neg ? kws_pkg::Y_MIN : kws_pkg::Y_MAX;
    end else if (r_side.n_zero) begin
      y_next = kws_pkg::Y_MIN;
    end else if (r_neg) begin
      y_next = (mag > 17'd32768) ? kws_pkg::Y_MIN : 16'(-mag);
    end else begin
      y_next = (mag > 17'd32767) ? kws_pkg::Y_MAX : 16'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      y_valid <= 1'b0;
    end else if (en) begin
      y_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= y_next;
      y_side <= r_side;
    end
  end

  // Output stage: window checks.
  logic [1:0] lo_i;
  logic [1:0] hi_i;
  logic       pass_next;
  logic       out_cls;

  assign lo_i = {y_side.cls, 1'b0};
  assign hi_i = {y_side.cls, 1'b1};

  always_comb begin
    logic signed [CW-1:0] ys;
    ys = CW'(y_r);
    pass_next =
      CW'(y_side.pt) >= CW'(fld[kws_pkg::REG_PT][lo_i]) &&
      CW'(y_side.pt) <= CW'(fld[kws_pkg::REG_PT][hi_i]) &&
      CW'(y_side.p) >= CW'(fld[kws_pkg::REG_MOM][lo_i]) &&
      CW'(y_side.p) <= CW'(fld[kws_pkg::REG_MOM][hi_i]) &&
      CW'(y_side.theta) >= CW'(fld[kws_pkg::REG_THETA][lo_i]) &&
      CW'(y_side.theta) <= CW'(fld[kws_pkg::REG_THETA][hi_i]) &&
      ys >= CW'($signed(fld[kws_pkg::REG_RAP][lo_i])) &&
      ys <= CW'($signed(fld[kws_pkg::REG_RAP][hi_i])) &&
      CW'(y_side.phi) >= CW'(fld[kws_pkg::REG_PHI][lo_i]) &&
      CW'(y_side.phi) <= CW'(fld[kws_pkg::REG_PHI][hi_i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.valid <= 1'b0;
    end else if (en) begin
      item_out.valid <= y_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_out.accepted <= pass_next;
      item_out.rapidity <= y_r;
      out_cls <= y_side.cls;
    end
  end

`ifndef NO_ASSERTIONS
  a_tzero_sat: assert property (@(posedge clk) disable iff (rst)
    (y_valid && y_side.t_zero) |-> (y_r == kws_pkg::Y_MAX || y_r == kws_pkg::Y_MIN))
    else $error("rapidity not saturated for zero transverse mass");

  a_acc_rap: assert property (@(posedge clk) disable iff (rst)
    (item_out.valid && item_out.accepted) |->
      (CW'(item_out.rapidity) >= CW'($signed(fld[kws_pkg::REG_RAP][{out_cls, 1'b0}])) &&
       CW'(item_out.rapidity) <= CW'($signed(fld[kws_pkg::REG_RAP][{out_cls, 1'b1}]))))
    else $error("accepted item has rapidity outside its window");

  a_reset_empty: assert property (@(posedge clk) rst |=> !item_out.valid)
    else $error("result item presented right after reset");
`endif

endmodule
